/* rtl/kru_pkg.sv */
package kru_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int KEY_W   = 48;
  localparam int DATA_W  = 48;
  localparam int MODE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [MODE_W-1:0] MODE_GUESSED = 8'd71;
  localparam logic [MODE_W-1:0] MODE_USERSET = 8'd85;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_KEPT    = 2'd2,
    ACT_DROP    = 2'd3
  } action_t;

  typedef struct packed {
    logic [TIME_W-1:0] change_time;
    logic [MODE_W-1:0] entry_mode;
    logic [DATA_W-1:0] home_bbs;
    logic [KEY_W-1:0]  call_sign;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic more;
    logic pending;
    logic out_free;
  } status_t;

endpackage

/* rtl/keyed_record_upsert_table.sv */
// an accepted item is registered, then the searchable entries are scanned by key at one
//   table read per cycle; the scan ends early when a key matches, then the action is
//   applied and the result moves to the output register once that register is free
// a new item is taken only after the previous result has reached the output register,
//   and it is taken while that result still waits in the output register
// reset clears entry and searchable counts and the output valid; table untouched
module keyed_record_upsert_table import kru_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // call_sign, home_bbs, entry_mode, change_time
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // action, slot, stored_count, zero pad
  output logic [23:0]  m_axis_tdata
);

  cmd_t               cmd;
  status_t            st;
  entry_t             in_entry;
  action_t            out_action;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_count;

  assign in_entry.call_sign   = s_axis_tdata[47:0];
  assign in_entry.home_bbs    = s_axis_tdata[95:48];
  assign in_entry.entry_mode  = s_axis_tdata[103:96];
  assign in_entry.change_time = s_axis_tdata[135:104];

  assign m_axis_tdata = {5'd0, out_count, out_slot, out_action};

  kru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  kru_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_entry   (in_entry),
    .in_last    (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_action (out_action),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

endmodule

/* rtl/kru_ram.sv */
module kru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/kru_ctrl.sv */
module kru_ctrl import kru_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.hit || (!st.more && !st.pending)) begin
          state_next = ST_APPLY;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/kru_dp.sv */
module kru_dp import kru_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            st,
  input  entry_t             in_entry,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output action_t            out_action,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t          item;
  logic            item_last;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   searchable_count;
  logic [CW-1:0]   ptr;
  logic            cmp_valid;
  logic [AW-1:0]   cmp_idx;
  entry_t          rd_q;

  action_t         res_action;
  logic [SLOT_W-1:0]  res_slot;
  logic [COUNT_W-1:0] res_count;

  logic            more;
  logic            hit;
  logic            rd_en;
  action_t         act;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   slot_sel;
  logic [CW-1:0]   count_next;
  logic [31:0]     slot_wide;
  logic [31:0]     count_wide;

  assign more  = ptr < searchable_count;
  assign hit   = cmp_valid && (rd_q.call_sign == item.call_sign);
  assign rd_en = cmd.issue && more;

  assign st.hit      = hit;
  assign st.more     = more;
  assign st.pending  = cmp_valid;
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    act = ACT_APPEND;
    if (hit) begin
      if (rd_q.entry_mode == item.entry_mode) begin
        act = (rd_q.change_time >= item.change_time) ? ACT_KEPT : ACT_REPLACE;
      end else if (rd_q.entry_mode == MODE_GUESSED && item.entry_mode == MODE_USERSET) begin
        act = ACT_REPLACE;
      end
    end
    if (act == ACT_APPEND && entry_count == CW'(TABLE_DEPTH)) begin
      act = ACT_DROP;
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = cmp_idx;
    slot_sel   = cmp_idx;
    count_next = entry_count;
    case (act)
      ACT_APPEND: begin
        wr_en      = cmd.apply;
        wr_addr    = entry_count[AW-1:0];
        slot_sel   = entry_count[AW-1:0];
        count_next = entry_count + CW'(1);
      end
      ACT_REPLACE: begin
        wr_en = cmd.apply;
      end
      ACT_KEPT: begin
        wr_en = 1'b0;
      end
      ACT_DROP: begin
        slot_sel = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign slot_wide  = 32'(slot_sel);
  assign count_wide = 32'(count_next);

  kru_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item),
    .re    (rd_en),
    .raddr (ptr[AW-1:0]),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item      <= in_entry;
      item_last <= in_last;
      ptr       <= '0;
    end else if (rd_en) begin
      ptr     <= ptr + CW'(1);
      cmp_idx <= ptr[AW-1:0];
    end
    if (cmd.apply) begin
      res_action <= act;
      res_slot   <= slot_wide[SLOT_W-1:0];
      res_count  <= count_wide[COUNT_W-1:0];
    end
    if (cmd.out_load) begin
      out_action <= res_action;
      out_slot   <= res_slot;
      out_count  <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      searchable_count <= '0;
      cmp_valid        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.load) begin
        cmp_valid <= 1'b0;
      end else if (cmd.issue) begin
        cmp_valid <= more;
      end
      if (cmd.apply) begin
        entry_count <= count_next;
        if (item_last) begin
          searchable_count <= count_next;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* test/tb_keyed_record_upsert_table.sv */
module tb_keyed_record_upsert_table;
  import kru_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 600;
  localparam int HOLD_CYCLES = 1500;
  localparam int KEY_POOL = 48;
  localparam logic [47:0] ONES48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] TEST_KEY = 48'h5445_5354_3031;

  typedef struct packed {
    action_t     act;
    logic [7:0]  slot;
    logic [8:0]  cnt;
  } upsert_res_t;

  typedef struct packed {
    entry_t      rec;
    logic        last;
    logic        typed;
    upsert_res_t res;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;

  // table mirror
  entry_t      tbl [DEPTH];
  int unsigned n_entries = 0;
  int unsigned n_searchable = 0;

  upsert_res_t pending_results[$];
  upsert_res_t next_result;
  plan_row_t   directed_rows[$];
  logic [47:0] key_pool [KEY_POOL];

  int mismatches = 0;
  int records_sent = 0;
  int act_seen [4] = '{0, 0, 0, 0};
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;

  keyed_record_upsert_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic upsert_res_t predict_upsert(entry_t rec, logic last);
    upsert_res_t r;
    bit hit;
    r.act = ACT_APPEND;
    r.slot = '0;
    hit = 1'b0;
    for (int i = 0; i < n_searchable; i++) begin
      if (!hit && tbl[i].call_sign == rec.call_sign) begin
        hit = 1'b1;
        r.slot = 8'(i);
        if (tbl[i].entry_mode == rec.entry_mode) begin
          r.act = (tbl[i].change_time >= rec.change_time) ? ACT_KEPT : ACT_REPLACE;
        end else if (tbl[i].entry_mode == MODE_GUESSED && rec.entry_mode == MODE_USERSET) begin
          r.act = ACT_REPLACE;
        end
      end
    end
    if (r.act == ACT_REPLACE) begin
      tbl[r.slot] = rec;
    end else if (r.act == ACT_APPEND) begin
      if (n_entries < DEPTH) begin
        r.slot = 8'(n_entries);
        tbl[n_entries] = rec;
        n_entries++;
      end else begin
        r.act = ACT_DROP;
        r.slot = '0;
      end
    end
    if (last) n_searchable = n_entries;
    r.cnt = 9'(n_entries);
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic entry_t random_record();
    entry_t rec;
    int pick;
    rec.call_sign = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)] : rand48();
    rec.home_bbs = rand48();
    pick = $urandom_range(99);
    if (pick < 45) rec.entry_mode = MODE_GUESSED;
    else if (pick < 90) rec.entry_mode = MODE_USERSET;
    else rec.entry_mode = 8'($urandom);
    pick = $urandom_range(99);
    // small times make ties and older/newer pairs common
    if (pick < 60) rec.change_time = 32'($urandom_range(20));
    else if (pick < 90) rec.change_time = $urandom;
    else rec.change_time = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    return rec;
  endfunction

  task automatic add_row(input logic [47:0] key, input logic [47:0] data,
                         input logic [7:0] mode, input logic [31:0] t, input logic last,
                         input logic typed, input action_t act, input int slot, input int cnt);
    plan_row_t row;
    row.rec.call_sign = key;
    row.rec.home_bbs = data;
    row.rec.entry_mode = mode;
    row.rec.change_time = t;
    row.last = last;
    row.typed = typed;
    row.res.act = act;
    row.res.slot = 8'(slot);
    row.res.cnt = 9'(cnt);
    directed_rows.push_back(row);
  endtask

  task automatic send_record(input entry_t rec, input logic last, input logic typed,
                             input upsert_res_t typed_res);
    upsert_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rec;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    r = predict_upsert(rec, last);
    pending_results.push_back(typed ? typed_res : r);
    records_sent++;
  endtask

  // output side pacing, with one long hold-off
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act_seen[m_axis_tdata[1:0]]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, m_axis_tdata);
        mismatches++;
      end else begin
        next_result = pending_results.pop_front();
        if (m_axis_tdata[1:0] != next_result.act) begin
          $display("%0t: action expected %0d actual %0d", $time, next_result.act,
                   m_axis_tdata[1:0]);
          mismatches++;
        end
        if (m_axis_tdata[9:2] != next_result.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, next_result.slot,
                   m_axis_tdata[9:2]);
          mismatches++;
        end
        if (m_axis_tdata[18:10] != next_result.cnt) begin
          $display("%0t: stored_count expected %0d actual %0d", $time, next_result.cnt,
                   m_axis_tdata[18:10]);
          mismatches++;
        end
        if (m_axis_tdata[23:19] != '0) begin
          $display("%0t: pad expected 0 actual %h", $time, m_axis_tdata[23:19]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    entry_t rec;
    logic last;
    int len;
    int phase_sent;

    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = rand48();

    // after reset, extremes, mode pairs, same-source duplicates
    add_row(48'h0, 48'h0, MODE_GUESSED, 32'd0, 1'b0, 1'b1, ACT_APPEND, 0, 1);
    add_row(ONES48, ONES48, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ACT_APPEND, 1, 2);
    add_row(48'h0, 48'h4242_4242_4242, MODE_GUESSED, 32'd5, 1'b0, 1'b1, ACT_REPLACE, 0, 2);
    add_row(48'h0, 48'h1, MODE_GUESSED, 32'd5, 1'b0, 1'b1, ACT_KEPT, 0, 2);
    add_row(48'h0, 48'h2, MODE_USERSET, 32'd0, 1'b0, 1'b1, ACT_REPLACE, 0, 2);
    add_row(48'h0, 48'h3, MODE_GUESSED, 32'd100, 1'b0, 1'b1, ACT_APPEND, 2, 3);
    add_row(ONES48, 48'h0, 8'hFF, 32'd0, 1'b0, 1'b1, ACT_KEPT, 1, 3);
    add_row(ONES48, 48'h0, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, ACT_KEPT, 1, 3);
    add_row(TEST_KEY, 48'h4242_5331_3233, MODE_GUESSED, 32'd1000, 1'b0, 1'b1, ACT_APPEND, 3, 4);
    add_row(TEST_KEY, 48'h4242_5331_3234, MODE_GUESSED, 32'd2000, 1'b1, 1'b1, ACT_APPEND, 4, 5);
    add_row(TEST_KEY, 48'h4242_5331_3235, MODE_GUESSED, 32'd3000, 1'b0, 1'b1, ACT_REPLACE, 3, 5);
    add_row(48'h0, 48'h4, MODE_USERSET, 32'hFFFF_FFFF, 1'b0, 1'b1, ACT_REPLACE, 0, 5);
    add_row(48'h0, 48'h5, MODE_USERSET, 32'd7, 1'b0, 1'b1, ACT_KEPT, 0, 5);
    add_row(ONES48, 48'h6, MODE_GUESSED, 32'd1, 1'b0, 1'b1, ACT_APPEND, 5, 6);
    add_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 8'h00, 32'h8000_0000, 1'b1, 1'b1,
            ACT_APPEND, 6, 7);
    add_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 8'hAA, 32'h7FFF_FFFF, 1'b0, 1'b1,
            ACT_APPEND, 7, 8);
    add_row(ONES48, 48'h7, MODE_GUESSED, 32'd0, 1'b0, 1'b1, ACT_APPEND, 8, 9);
    add_row(48'hAAAA_AAAA_AAAA, 48'h8, 8'h00, 32'h8000_0000, 1'b0, 1'b1, ACT_KEPT, 6, 9);
    add_row(48'hAAAA_AAAA_AAAA, 48'h9, 8'h00, 32'h8000_0001, 1'b1, 1'b1, ACT_REPLACE, 6, 9);
    add_row(48'h5555_5555_5555, 48'hA, MODE_USERSET, 32'd0, 1'b0, 1'b0, ACT_APPEND, 0, 0);
    add_row(TEST_KEY, 48'hB, MODE_USERSET, 32'd0, 1'b0, 1'b0, ACT_APPEND, 0, 0);
    add_row(48'h0, 48'hC, MODE_GUESSED, 32'd50, 1'b1, 1'b0, ACT_APPEND, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 88;
    foreach (directed_rows[i])
      send_record(directed_rows[i].rec, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_go = 1'b1;
        end
      endcase
      phase_sent = 0;
      while (phase_sent < RANDOM_PER_PHASE) begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          rec = random_record();
          last = (j == len - 1);
          if ($urandom_range(99) < 5) last = $urandom_range(1);
          send_record(rec, last, 1'b0, '0);
          phase_sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    $display("%0d records merged: %0d directed, the rest in random sources under three pacings",
             records_sent, directed_rows.size());
    $display("appended %0d, replaced %0d, kept out %0d, dropped on a full table %0d",
             act_seen[ACT_APPEND], act_seen[ACT_REPLACE], act_seen[ACT_KEPT],
             act_seen[ACT_DROP]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
